FILE: rtl/html_text_escaper_macros.svh
// Assertion macros shared by the checker files of the HTML text escaper.
`ifndef HTML_TEXT_ESCAPER_MACROS_SVH
`define HTML_TEXT_ESCAPER_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define HTE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hte: implication check failed");

// Next-cycle implication, masked while reset is high.
`define HTE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hte: next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define HTE_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("hte: reset-time check failed");

`endif

FILE: rtl/hte_pkg.sv
// Shared types, constants and character functions of the HTML text escaper.
package hte_pkg;

   // Queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Line-break pairing state
   localparam logic [1:0] SKIP_NONE = 2'd0;
   localparam logic [1:0] SKIP_CR   = 2'd1;
   localparam logic [1:0] SKIP_LF   = 2'd2;

   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_QUOT = 8'h22;
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_GT   = 8'h3E;

   typedef enum logic [2:0] {
      KIND_LETTER,
      KIND_NBSP,
      KIND_AMP,
      KIND_LT,
      KIND_GT,
      KIND_QUOT,
      KIND_BR,
      KIND_HEX
   } hte_kind_type;

   typedef struct packed {
      hte_kind_type kind;
      logic [7:0]   text_byte;
   } hte_item_type;

   typedef struct packed {
      logic         valid;
      hte_item_type item;
   } hte_push_type;

   typedef struct packed {
      logic         valid;
      hte_item_type item;
   } hte_head_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + {4'h0, v};
      end else begin
         return 8'h37 + {4'h0, v};
      end
   endfunction

   // Index of the final character of a run
   function automatic logic [2:0] run_last_idx(input hte_kind_type kind);
      logic [2:0] r;
      unique case (kind) inside
         KIND_LETTER:         r = 3'd0;
         KIND_AMP:            r = 3'd4;
         KIND_LT, KIND_GT:    r = 3'd3;
         default:             r = 3'd5;
      endcase
      return r;
   endfunction

   // Character idx of the run for one item; text is left-aligned in 48 bits
   function automatic logic [7:0] run_char(input hte_item_type it, input logic [2:0] idx);
      logic [47:0] s;
      logic [47:0] sh;
      unique case (it.kind)
         KIND_LETTER: s = {it.text_byte, 40'h0};
         KIND_NBSP:   s = "&nbsp;";
         KIND_AMP:    s = {"&amp;", 8'h00};
         KIND_LT:     s = {"&lt;", 16'h0000};
         KIND_GT:     s = {"&gt;", 16'h0000};
         KIND_QUOT:   s = "&quot;";
         KIND_BR:     s = {"<BR>", CH_CR, CH_LF};
         default:     s = {"&#x", hex_digit(it.text_byte[7:4]),
                           hex_digit(it.text_byte[3:0]), ";"};
      endcase
      sh = s << {idx, 3'b000};
      return sh[47:40];
   endfunction

endpackage

FILE: rtl/hte_front.sv
// Front end: input handshake, line-break pairing and byte classification.
module hte_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_text_byte,
   input  logic                 req_last_in_text,
   input  logic                 q_full,
   output hte_pkg::hte_push_type push
);

   logic [1:0]            skip_ff, skip_in;
   logic                  accept;
   logic                  drop;
   hte_pkg::hte_kind_type kind;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign drop = (skip_ff == hte_pkg::SKIP_CR && req_text_byte == hte_pkg::CH_CR) ||
                 (skip_ff == hte_pkg::SKIP_LF && req_text_byte == hte_pkg::CH_LF);

   always_comb begin
      unique case (req_text_byte) inside
         [8'h41:8'h5A], [8'h61:8'h7A]:   kind = hte_pkg::KIND_LETTER;
         hte_pkg::CH_SP:                 kind = hte_pkg::KIND_NBSP;
         hte_pkg::CH_AMP:                kind = hte_pkg::KIND_AMP;
         hte_pkg::CH_LT:                 kind = hte_pkg::KIND_LT;
         hte_pkg::CH_GT:                 kind = hte_pkg::KIND_GT;
         hte_pkg::CH_QUOT:               kind = hte_pkg::KIND_QUOT;
         hte_pkg::CH_LF, hte_pkg::CH_CR: kind = hte_pkg::KIND_BR;
         default:                        kind = hte_pkg::KIND_HEX;
      endcase
   end

   always_comb begin
      skip_in = hte_pkg::SKIP_NONE;
      if (!drop && !req_last_in_text) begin
         if (req_text_byte == hte_pkg::CH_LF) begin
            skip_in = hte_pkg::SKIP_CR;
         end else if (req_text_byte == hte_pkg::CH_CR) begin
            skip_in = hte_pkg::SKIP_LF;
         end
      end
   end

   // a dropped byte leaves no entry in the queue
   assign push.valid          = accept && !drop;
   assign push.item.kind      = kind;
   assign push.item.text_byte = req_text_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= hte_pkg::SKIP_NONE;
      end else if (accept) begin
         skip_ff <= skip_in;
      end
   end

endmodule

FILE: rtl/hte_queue.sv
// Small register queue of classified bytes between front and back.
module hte_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  hte_pkg::hte_push_type push,
   input  logic                  pop,
   output logic                  full,
   output hte_pkg::hte_head_type head
);

   hte_pkg::hte_item_type             mem_ff [hte_pkg::QDEPTH];
   logic [hte_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [hte_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [hte_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   localparam logic [hte_pkg::QPTR_W-1:0] PTR_LAST = hte_pkg::QPTR_W'(hte_pkg::QDEPTH - 1);
   localparam logic [hte_pkg::QCNT_W-1:0] CNT_FULL = hte_pkg::QCNT_W'(hte_pkg::QDEPTH);

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

FILE: rtl/hte_back.sv
// Back end: walks the character run of the head item into the output register.
module hte_back (
   input  logic                  clock,
   input  logic                  reset,
   input  hte_pkg::hte_head_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_out_last
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       run_end;

   // output slot free or being emptied this cycle
   assign load    = head.valid && (!rsp_valid_ff || rsp_ready);
   assign run_end = (idx_ff == hte_pkg::run_last_idx(head.item.kind));
   assign pop     = load && run_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         char_in      = hte_pkg::run_char(head.item, idx_ff);
         last_in      = run_end;
         idx_in       = run_end ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

endmodule

FILE: rtl/html_text_escaper.sv
// HTML text escaper top level: byte in, HTML character run out.
//
// Input channel req_*: one text byte per transaction, req_last_in_text marks
// the final byte of a text. Output channel rsp_*: one HTML character per
// transaction, rsp_out_last high on the final character of a byte's run.
// Letters give one character, "<" and ">" four, "&" five, everything else
// six. A CR following an LF (or LF following CR) inside a text gives none.
// Throughput: the back end sends one character per cycle while rsp_ready is
// high and a byte is queued, one character of the byte's run at a time; the
// front takes a byte every cycle while the two-entry queue has room.
// An accepted byte is written into the queue; once it is the queue head and
// the output register is free, its first character is loaded onto rsp_*.
// Reset (synchronous, active high) empties the queue, clears the output valid
// flag and forgets any pending line-break pairing.
// When the receiver holds rsp_ready low the output character stays put, the
// queue fills, and req_ready drops once it is full.
module html_text_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_last_in_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);

   hte_pkg::hte_push_type push;
   hte_pkg::hte_head_type head;
   logic                  q_full;
   logic                  pop;

   hte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_last_in_text (req_last_in_text),
      .q_full           (q_full),
      .push             (push)
   );

   hte_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   hte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: rtl/hte_checker.sv
// Port-level checker for the HTML text escaper and its bind.
`include "html_text_escaper_macros.svh"

module hte_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_out_last
);

   `HTE_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

   `HTE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_char) && $stable(rsp_out_last))

   // a semicolon only ever closes an entity
   `HTE_ASSERT_IMP(a_semi_last, clock, reset, rsp_valid && rsp_out_char == hte_pkg::CH_SEMI, rsp_out_last)

   // an ampersand only ever opens an entity
   `HTE_ASSERT_IMP(a_amp_first, clock, reset, rsp_valid && rsp_out_char == hte_pkg::CH_AMP, !rsp_out_last)

endmodule

bind html_text_escaper hte_checker u_hte_checker (.*);

FILE: tb/html_text_escaper_checker.sv
`timescale 1ns / 1ps
// Checker for the HTML text escaper: predicts each character run and compares responses.
module html_text_escaper_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_last_in_text,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_out_last,
   output int         fail_count,
   output int         pending_chars
);

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } html_char_type;

   html_char_type expected_chars[$];
   logic [1:0]    line_skip;
   int            errs = 0;

   function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + v;
      end
      return 8'h41 + (v - 4'd10);
   endfunction

   function automatic void push_char(input logic [7:0] ch, input logic last);
      html_char_type c;
      c.ch = ch;
      c.last = last;
      expected_chars.push_back(c);
   endfunction

   // push a literal run; ends marks its final char as the end of the byte's output
   function automatic void push_text(input string s, input logic ends);
      for (int k = 0; k < s.len(); k++) begin
         push_char(s[k], ends && (k == s.len() - 1));
      end
   endfunction

   function automatic void escape_byte(input logic [7:0] b, input logic last_in_text);
      logic [1:0] pend;
      pend = line_skip;
      line_skip = hte_pkg::SKIP_NONE;
      // second half of a CR/LF or LF/CR pair is swallowed
      if ((pend == hte_pkg::SKIP_CR && b == hte_pkg::CH_CR) ||
          (pend == hte_pkg::SKIP_LF && b == hte_pkg::CH_LF)) begin
         return;
      end
      if (!last_in_text) begin
         if (b == hte_pkg::CH_LF) begin
            line_skip = hte_pkg::SKIP_CR;
         end else if (b == hte_pkg::CH_CR) begin
            line_skip = hte_pkg::SKIP_LF;
         end
      end
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
         push_char(b, 1'b1);
         return;
      end
      case (b) inside
         hte_pkg::CH_SP:   push_text("&nbsp;", 1'b1);
         hte_pkg::CH_AMP:  push_text("&amp;", 1'b1);
         hte_pkg::CH_LT:   push_text("&lt;", 1'b1);
         hte_pkg::CH_GT:   push_text("&gt;", 1'b1);
         hte_pkg::CH_QUOT: push_text("&quot;", 1'b1);
         hte_pkg::CH_LF, hte_pkg::CH_CR: begin
            push_text("<BR>", 1'b0);
            push_char(hte_pkg::CH_CR, 1'b0);
            push_char(hte_pkg::CH_LF, 1'b1);
         end
         default: begin
            push_text("&#x", 1'b0);
            push_char(nibble_ascii(b[7:4]), 1'b0);
            push_char(nibble_ascii(b[3:0]), 1'b0);
            push_char(hte_pkg::CH_SEMI, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      html_char_type exp_c;
      if (reset) begin
         expected_chars.delete();
         line_skip = hte_pkg::SKIP_NONE;
      end else begin
         // responses first: a request at this edge cannot already be answered
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected rsp transaction, expected none, got char %h last %b",
                        $time, rsp_out_char, rsp_out_last);
               errs++;
            end else begin
               exp_c = expected_chars.pop_front();
               if (rsp_out_char !== exp_c.ch) begin
                  $display("%0t: out_char mismatch, expected %h, got %h",
                           $time, exp_c.ch, rsp_out_char);
                  errs++;
               end
               if (rsp_out_last !== exp_c.last) begin
                  $display("%0t: out_last mismatch, expected %b, got %b",
                           $time, exp_c.last, rsp_out_last);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            escape_byte(req_text_byte, req_last_in_text);
         end
      end
      fail_count <= errs;
      pending_chars <= expected_chars.size();
   end

endmodule

FILE: tb/html_text_escaper_tb.sv
`timescale 1ns / 1ps
// Testbench top for the HTML text escaper: reset, stimulus, flow control and verdict.
module html_text_escaper_tb;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 20;
   localparam int BYTES_PER_PHASE  = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_last_in_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_out_last;

   int fail_count;
   int pending_chars;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   html_text_escaper dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_last_in_text (req_last_in_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_out_last     (rsp_out_last)
   );

   html_text_escaper_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_last_in_text (req_last_in_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_out_last     (rsp_out_last),
      .fail_count       (fail_count),
      .pending_chars    (pending_chars)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("html_text_escaper_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one byte; returns right after the edge that accepts it
   task automatic send_byte(input logic [7:0] b, input logic last_in_text);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_last_in_text <= last_in_text;
      do @(posedge clock); while (!req_ready);
   endtask

   // weighted toward line breaks and entities so pairing and all run lengths show up often
   function automatic logic [7:0] random_text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 30) begin
         return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25));
      end else if (r < 45) begin
         case ($urandom_range(4))
            0:       return hte_pkg::CH_SP;
            1:       return hte_pkg::CH_AMP;
            2:       return hte_pkg::CH_LT;
            3:       return hte_pkg::CH_GT;
            default: return hte_pkg::CH_QUOT;
         endcase
      end else if (r < 70) begin
         return $urandom_range(1) ? hte_pkg::CH_LF : hte_pkg::CH_CR;
      end
      return 8'($urandom_range(255));
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // letter boundaries and their neighbors, entities, hex forms
      send_byte("A", 1'b0);
      send_byte("z", 1'b0);
      send_byte("@", 1'b0);
      send_byte("{", 1'b0);
      send_byte(hte_pkg::CH_SP, 1'b0);
      send_byte(hte_pkg::CH_AMP, 1'b0);
      send_byte(hte_pkg::CH_LT, 1'b0);
      send_byte(hte_pkg::CH_GT, 1'b0);
      send_byte(hte_pkg::CH_QUOT, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte("9", 1'b0);
      send_byte(8'h09, 1'b1);
      // line break pairing
      send_byte(hte_pkg::CH_LF, 1'b0);
      send_byte(hte_pkg::CH_CR, 1'b0);   // dropped
      send_byte(hte_pkg::CH_CR, 1'b0);
      send_byte(hte_pkg::CH_LF, 1'b0);   // dropped
      send_byte(hte_pkg::CH_LF, 1'b0);
      send_byte(hte_pkg::CH_LF, 1'b0);   // same kind, not dropped
      send_byte("x", 1'b0);              // cancels pending skip
      send_byte(hte_pkg::CH_LF, 1'b1);   // end of text, no skip armed
      send_byte(hte_pkg::CH_CR, 1'b0);
      send_byte(hte_pkg::CH_LF, 1'b1);   // dropped, and text ends

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 14;
               recv_stall_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_stall_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < BYTES_PER_PHASE; n++) begin
            send_byte(random_text_byte(), $urandom_range(7) == 0);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_chars != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_chars == 0) begin
         $display("html_text_escaper_tb: done, clean");
      end else begin
         if (pending_chars != 0) begin
            $display("%0t: %0d expected characters never arrived", $time, pending_chars);
         end
         $display("html_text_escaper_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: html_text_escaper.f
+incdir+rtl
rtl/hte_pkg.sv
rtl/hte_front.sv
rtl/hte_queue.sv
rtl/hte_back.sv
rtl/html_text_escaper.sv
rtl/hte_checker.sv
tb/html_text_escaper_checker.sv
tb/html_text_escaper_tb.sv
